// ----- design/pixel_format_to_rgba_unpacker_top_defines.svh -----
// assertion macros for the pixel format unpacker
`ifndef PIXEL_FORMAT_TO_RGBA_UNPACKER_TOP_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGBA_UNPACKER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define PFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pfu check failed");

// next-cycle implication, held off during reset
`define PFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pfu check failed");

`endif

// ----- design/pfu_pkg.sv -----
// shared types and format codes for the pixel format unpacker
package pfu_pkg;

	typedef enum logic [4:0] {
		FMT_L1_MSB   = 5'd0,
		FMT_L1_LSB   = 5'd1,
		FMT_L2_MSB   = 5'd2,
		FMT_L2_LSB   = 5'd3,
		FMT_L4_HI    = 5'd4,
		FMT_L4_LO    = 5'd5,
		FMT_L8       = 5'd6,
		FMT_RGB888   = 5'd7,
		FMT_BGR888   = 5'd8,
		FMT_ARGB8888 = 5'd9,
		FMT_ABGR8888 = 5'd10,
		FMT_RGBA8888 = 5'd11,
		FMT_BGRA8888 = 5'd12,
		FMT_XRGB8888 = 5'd13,
		FMT_XBGR8888 = 5'd14,
		FMT_RGBX8888 = 5'd15,
		FMT_BGRX8888 = 5'd16
	} fmt_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       run_last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// one byte's worth of work handed to the emitter
	typedef struct packed {
		fmt_t       fmt;
		logic [7:0] data_byte;
		pixel_t     pix;
		logic [2:0] last_idx;
	} job_t;

	typedef struct packed {
		logic [1:0] phase;
	} asm_status_t;

endpackage

// ----- design/pixel_format_to_rgba_unpacker_top.sv -----
// channel       | dir | payload                          | handshake
// src           | in  | data_byte, buffer_end             | src_valid / src_ready
// pix           | out | red, green, blue, alpha, run_last | pix_valid / pix_ready
// cfg           | in  | source_format (5 bits)            | cfg_valid / cfg_ready
//
// one source word per cycle unless pix stalls, in 8-bit grey and the packed formats
// a grey byte of n pixels (n = 8, 4 or 2) holds the job stage, one pixel a cycle unless stalled
// a pixel goes from its taken word through the job stage, then the output register
// a stalled pix channel holds the job stage, which then holds src_ready low
// reset: format 8-bit grey, nothing held; cfg_ready is always high
module pixel_format_to_rgba_unpacker_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  pfu_pkg::in_word_t  src_word,
	output logic               pix_valid,
	input  logic               pix_ready,
	output pfu_pkg::out_word_t pix_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);
	import pfu_pkg::*;

`include "pixel_format_to_rgba_unpacker_top_defines.svh"

	logic        job_valid;
	logic        job_ready;
	job_t        job;
	asm_status_t status;

	assign cfg_ready = 1'b1;
	assign src_ready = job_ready;

	pfu_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_ready (job_ready),
		.src_word  (src_word),
		.job_valid (job_valid),
		.job       (job),
		.status    (status)
	);

	pfu_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word)
	);

	// a job only ever comes from a word taken this cycle
	`PFU_ASSERT_NOW(a_job_from_accept, clk, arst_n, job_valid, src_valid && src_ready)
	// a buffer end drops any partial pixel
	`PFU_ASSERT_NEXT(a_end_clears, clk, arst_n, src_valid && src_ready && src_word.buffer_end,
		status.phase == 2'd0)
	// a format write drops any partial pixel
	`PFU_ASSERT_NEXT(a_cfg_clears, clk, arst_n, cfg_valid && cfg_ready, status.phase == 2'd0)

endmodule

// ----- design/pfu_assembler.sv -----
// format register, packed pixel assembly and per-byte pixel count
module pfu_assembler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [4:0]          cfg_data,
	input  logic                src_valid,
	input  logic                src_ready,
	input  pfu_pkg::in_word_t   src_word,
	output logic                job_valid,
	output pfu_pkg::job_t       job,
	output pfu_pkg::asm_status_t status
);
	import pfu_pkg::*;

	fmt_t        fmt_q;
	logic [1:0]  phase_q;
	logic [23:0] held_q;

	logic        accept;
	logic [7:0]  b0, b1, b2, b3;
	logic [1:0]  need;
	logic        complete;
	logic        has_pix;
	logic [2:0]  last_idx;
	pixel_t      pix;

	assign accept = src_valid && src_ready;

	always_comb begin
		if (fmt_q <= FMT_BGR888) begin
			need = 2'd2;
			b0   = held_q[15:8];
			b1   = held_q[7:0];
			b2   = src_word.data_byte;
			b3   = 8'h00;
		end else begin
			need = 2'd3;
			b0   = held_q[23:16];
			b1   = held_q[15:8];
			b2   = held_q[7:0];
			b3   = src_word.data_byte;
		end
		complete = phase_q >= need;
	end

	always_comb begin
		pix = '{red: b2, green: b1, blue: b0, alpha: 8'hFF};
		case (fmt_q)
			FMT_RGB888:   pix = '{red: b0, green: b1, blue: b2, alpha: 8'hFF};
			FMT_BGR888:   pix = '{red: b2, green: b1, blue: b0, alpha: 8'hFF};
			FMT_ARGB8888: pix = '{red: b1, green: b2, blue: b3, alpha: b0};
			FMT_ABGR8888: pix = '{red: b3, green: b2, blue: b1, alpha: b0};
			FMT_RGBA8888: pix = '{red: b0, green: b1, blue: b2, alpha: b3};
			FMT_BGRA8888: pix = '{red: b2, green: b1, blue: b0, alpha: b3};
			FMT_XRGB8888: pix = '{red: b1, green: b2, blue: b3, alpha: 8'hFF};
			FMT_XBGR8888: pix = '{red: b3, green: b2, blue: b1, alpha: 8'hFF};
			FMT_RGBX8888: pix = '{red: b0, green: b1, blue: b2, alpha: 8'hFF};
			default:      pix = '{red: b2, green: b1, blue: b0, alpha: 8'hFF};
		endcase
	end

	// how many pixels this byte yields, as index of the last one
	always_comb begin
		has_pix  = 1'b1;
		last_idx = 3'd0;
		case (fmt_q)
			FMT_L1_MSB, FMT_L1_LSB: last_idx = 3'd7;
			FMT_L2_MSB, FMT_L2_LSB: last_idx = 3'd3;
			FMT_L4_HI, FMT_L4_LO:   last_idx = 3'd1;
			FMT_L8:                 last_idx = 3'd0;
			default:                has_pix  = (fmt_q <= FMT_BGRX8888) && complete;
		endcase
	end

	assign job_valid = accept && has_pix;
	assign job       = '{fmt: fmt_q, data_byte: src_word.data_byte, pix: pix,
	                     last_idx: last_idx};
	assign status    = '{phase: phase_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_L8;
			phase_q <= 2'd0;
			held_q  <= 24'd0;
		end else if (cfg_valid) begin
			fmt_q   <= fmt_t'(cfg_data);
			phase_q <= 2'd0;
			held_q  <= 24'd0;
		end else if (accept) begin
			if (src_word.buffer_end || fmt_q <= FMT_L8 || fmt_q > FMT_BGRX8888 || complete) begin
				phase_q <= 2'd0;
				held_q  <= 24'd0;
			end else begin
				phase_q <= phase_q + 2'd1;
				held_q  <= {held_q[15:0], src_word.data_byte};
			end
		end
	end

endmodule

// ----- design/pfu_emitter.sv -----
// job stage, grey level expansion and output word register
module pfu_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  pfu_pkg::job_t      job,
	output logic               job_ready,
	output logic               pix_valid,
	input  logic               pix_ready,
	output pfu_pkg::out_word_t pix_word
);
	import pfu_pkg::*;

	function automatic logic [7:0] grey_level(input fmt_t f, input logic [7:0] v,
	                                          input logic [2:0] idx);
		logic [7:0] level;
		level = v;
		case (f)
			FMT_L1_MSB: level = {8{v[~idx]}};
			FMT_L1_LSB: level = {8{v[idx]}};
			FMT_L2_MSB: level = {4{v[{~idx[1:0], 1'b0} +: 2]}};
			FMT_L2_LSB: level = {4{v[{idx[1:0], 1'b0} +: 2]}};
			FMT_L4_HI:  level = idx[0] ? {2{v[3:0]}} : {2{v[7:4]}};
			FMT_L4_LO:  level = idx[0] ? {2{v[7:4]}} : {2{v[3:0]}};
			default:    level = v;
		endcase
		return level;
	endfunction

	job_t       job_s1;
	logic       job_valid_s1;
	logic [2:0] idx_q;
	out_word_t  pix_q;
	logic       pix_valid_q;

	logic       out_free;
	logic       move;
	logic       done;
	logic [7:0] lvl;
	out_word_t  next_word;

	assign out_free  = !pix_valid_q || pix_ready;
	assign move      = job_valid_s1 && out_free;
	assign done      = move && (idx_q == job_s1.last_idx);
	assign job_ready = !job_valid_s1 || done;

	always_comb begin
		lvl = grey_level(job_s1.fmt, job_s1.data_byte, idx_q);
		if (job_s1.fmt <= FMT_L8) begin
			next_word = '{red: lvl, green: lvl, blue: lvl, alpha: 8'hFF,
			              run_last: idx_q == job_s1.last_idx};
		end else begin
			next_word = '{red: job_s1.pix.red, green: job_s1.pix.green,
			              blue: job_s1.pix.blue, alpha: job_s1.pix.alpha,
			              run_last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= 3'd0;
		end else if (job_valid && job_ready) begin
			job_valid_s1 <= 1'b1;
			idx_q        <= 3'd0;
		end else if (done) begin
			job_valid_s1 <= 1'b0;
		end else if (move) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready)
			job_s1 <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (move) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move)
			pix_q <= next_word;
	end

	assign pix_valid = pix_valid_q;
	assign pix_word  = pix_q;

endmodule
